@@ hdl/cac_pkg.sv @@
// Shared widths, register indexes and reset values for the closest-approach checker.
`default_nettype none
package cac_pkg;

  localparam int POS_W      = 24;
  localparam int VEL_W      = 16;
  localparam int D_W        = 25;
  localparam int V_W        = 17;
  localparam int DV_W       = 42;
  localparam int VV_W       = 34;
  localparam int DD_W       = 50;
  localparam int DOT_W      = 44;
  localparam int V2_W       = 34;
  localparam int D2_W       = 50;
  localparam int D2S_W      = 58;
  localparam int Q_W        = 32;
  localparam int SAFE_W     = 16;
  localparam int HOR_W      = 23;
  localparam int DIST_W     = 30;
  localparam int ROOT_W     = 31;
  localparam int PROD_W     = 41;
  localparam int C_W        = 31;
  localparam int SQ_W       = 62;
  localparam int TQ_W       = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_STEPS  = 32;
  localparam int ROOT_STEPS = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_SAFETY  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZON = 8'd1;

  localparam logic [SAFE_W-1:0] SAFETY_RESET  = 16'd200;
  localparam logic [HOR_W-1:0]  HORIZON_RESET = 23'd196608;

  localparam logic [TQ_W-1:0] TQ_MAX = 32'h7FFF_FFFF;
  localparam logic [TQ_W-1:0] TQ_MIN = 32'h8000_0000;

endpackage
`default_nettype wire

@@ hdl/cac_if.sv @@
// Request, result and configuration channels of the closest-approach checker.
`default_nettype none
interface cac_pair_if;
  import cac_pkg::*;
  logic valid;
  logic ready;
  logic signed [POS_W-1:0] own_pos_x;
  logic signed [POS_W-1:0] own_pos_y;
  logic signed [POS_W-1:0] own_pos_z;
  logic signed [VEL_W-1:0] own_vel_x;
  logic signed [VEL_W-1:0] own_vel_y;
  logic signed [VEL_W-1:0] own_vel_z;
  logic signed [POS_W-1:0] peer_pos_x;
  logic signed [POS_W-1:0] peer_pos_y;
  logic signed [POS_W-1:0] peer_pos_z;
  logic signed [VEL_W-1:0] peer_vel_x;
  logic signed [VEL_W-1:0] peer_vel_y;
  logic signed [VEL_W-1:0] peer_vel_z;
  modport source (
    output valid, own_pos_x, own_pos_y, own_pos_z, own_vel_x, own_vel_y, own_vel_z,
    output peer_pos_x, peer_pos_y, peer_pos_z, peer_vel_x, peer_vel_y, peer_vel_z,
    input ready
  );
  modport sink (
    input valid, own_pos_x, own_pos_y, own_pos_z, own_vel_x, own_vel_y, own_vel_z,
    input peer_pos_x, peer_pos_y, peer_pos_z, peer_vel_x, peer_vel_y, peer_vel_z,
    output ready
  );
endinterface

interface cac_result_if;
  import cac_pkg::*;
  logic valid;
  logic ready;
  logic collision;
  logic [DIST_W-1:0] min_distance;
  logic signed [TQ_W-1:0] time_to_closest;
  modport source (output valid, collision, min_distance, time_to_closest, input ready);
  modport sink (input valid, collision, min_distance, time_to_closest, output ready);
endinterface

interface cac_cfg_if;
  import cac_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/closest_approach_collision_check.sv @@
// Closest-approach collision check: pipelined dot products, divider and square root.
// Pipeline: 3 product/sum stages, 33 divider stages, 4 closest-point stages, 32 root stages,
// then the output buffer.
// Throughput: one request per cycle; a 2-entry output buffer stalls the pipe only when full.
// Reset: clears all valid bits and the buffer; registers return to 200 cm and 3 s.
`default_nettype none
module closest_approach_collision_check (
  input  logic clk,
  input  logic rst,
  cac_cfg_if.sink      cfg,
  cac_pair_if.sink     pair,
  cac_result_if.source result
);
  import cac_pkg::*;

  typedef struct packed {
    logic valid;
    logic [2:0][D_W-1:0] d;
    logic [2:0][V_W-1:0] v;
  } s1_t;

  typedef struct packed {
    logic valid;
    logic [2:0][D_W-1:0] d;
    logic [2:0][V_W-1:0] v;
    logic [2:0][DV_W-1:0] dv;
    logic [2:0][VV_W-1:0] vv;
    logic [2:0][DD_W-1:0] dd;
  } s2_t;

  typedef struct packed {
    logic valid;
    logic [2:0][D_W-1:0] d;
    logic [2:0][V_W-1:0] v;
    logic [DOT_W-1:0] dot;
    logic [V2_W-1:0] v2;
    logic [D2_W-1:0] d2;
  } s3_t;

  typedef struct packed {
    logic valid;
    logic [V2_W-1:0] rem;
    logic [Q_W-1:0] low;
    logic [Q_W-1:0] q;
    logic [V2_W-1:0] v2;
    logic ovf;
    logic neg;
    logic vzero;
    logic [2:0][D_W-1:0] d;
    logic [2:0][V_W-1:0] v;
    logic [D2S_W-1:0] d2s;
  } div_t;

  typedef struct packed {
    logic valid;
    logic win;
    logic coll_en;
    logic [TQ_W-1:0] tq;
    logic [HOR_W-1:0] tqw;
    logic [2:0][D_W-1:0] d;
    logic [2:0][V_W-1:0] v;
    logic [D2S_W-1:0] d2s;
  } p1_t;

  typedef struct packed {
    logic valid;
    logic win;
    logic coll_en;
    logic [TQ_W-1:0] tq;
    logic [2:0][D_W-1:0] d;
    logic [2:0][PROD_W-1:0] prod;
    logic [D2S_W-1:0] d2s;
  } p2_t;

  typedef struct packed {
    logic valid;
    logic win;
    logic coll_en;
    logic [TQ_W-1:0] tq;
    logic [2:0][C_W-1:0] c;
    logic [D2S_W-1:0] d2s;
  } p3_t;

  typedef struct packed {
    logic valid;
    logic win;
    logic coll_en;
    logic [TQ_W-1:0] tq;
    logic [2:0][SQ_W-1:0] cc;
    logic [D2S_W-1:0] d2s;
  } p4_t;

  typedef struct packed {
    logic valid;
    logic coll_en;
    logic [TQ_W-1:0] tq;
    logic [SQ_W-1:0] n;
    logic [ROOT_W+1:0] rem;
    logic [ROOT_W-1:0] r;
  } sq_t;

  typedef struct packed {
    logic collision;
    logic [DIST_W-1:0] min_distance;
    logic [TQ_W-1:0] time_to_closest;
  } res_t;

  function automatic div_t div_step(input div_t a);
    logic [V2_W:0] rs;
    logic [V2_W:0] df;
    logic ge;
    div_t b;
    rs = {a.rem, a.low[Q_W-1]};
    ge = rs >= {1'b0, a.v2};
    df = rs - {1'b0, a.v2};
    b = a;
    b.rem = ge ? df[V2_W-1:0] : rs[V2_W-1:0];
    b.low = {a.low[Q_W-2:0], 1'b0};
    b.q = {a.q[Q_W-2:0], ge};
    return b;
  endfunction

  function automatic sq_t sq_step(input sq_t a);
    logic [ROOT_W+3:0] rs;
    logic [ROOT_W+3:0] t;
    logic [ROOT_W+3:0] df;
    logic ge;
    sq_t b;
    rs = {a.rem, a.n[SQ_W-1:SQ_W-2]};
    t = {2'b00, a.r, 2'b01};
    ge = rs >= t;
    df = rs - t;
    b = a;
    b.rem = ge ? df[ROOT_W+1:0] : rs[ROOT_W+1:0];
    b.r = {a.r[ROOT_W-2:0], ge};
    b.n = {a.n[SQ_W-3:0], 2'b00};
    return b;
  endfunction

  logic [SAFE_W-1:0] safety;
  logic [HOR_W-1:0] horizon;

  s1_t s1;
  s2_t s2;
  s3_t s3;
  div_t div_st [0:DIV_STEPS];
  p1_t p1;
  p2_t p2;
  p3_t p3;
  p4_t p4;
  sq_t sq [0:ROOT_STEPS];

  res_t buf0;
  res_t buf1;
  logic [1:0] cnt;
  logic en;
  logic push;
  logic pop;

  div_t div_init;
  p1_t p1_next;
  sq_t sq_init;
  res_t res_next;

  logic [DOT_W-1:0] mag;
  logic [Q_W:0] mneg;
  logic [Q_W:0] mneg_ext;
  logic remnz;
  logic win;
  logic [SQ_W-1:0] c2;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      safety <= SAFETY_RESET;
      horizon <= HORIZON_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_SAFETY:  safety <= cfg.data[SAFE_W-1:0];
        CFG_HORIZON: horizon <= cfg.data[HOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign en = (cnt != 2'd2);
  assign pair.ready = en;

  // divider setup: |num| = |dot| << 16, top part seeds the remainder
  always_comb begin
    mag = s3.dot[DOT_W-1] ? (~s3.dot + DOT_W'(1)) : s3.dot;
    div_init.valid = s3.valid;
    div_init.rem = V2_W'(mag[DOT_W-1:16]);
    div_init.low = {mag[15:0], 16'd0};
    div_init.q = '0;
    div_init.v2 = s3.v2;
    div_init.ovf = V2_W'(mag[DOT_W-1:16]) >= s3.v2;
    div_init.neg = !s3.dot[DOT_W-1] && (s3.dot != '0);
    div_init.vzero = (s3.v2 == '0);
    div_init.d = s3.d;
    div_init.v = s3.v;
    div_init.d2s = {s3.d2, 8'd0};
  end

  // time result, saturation and window test
  always_comb begin
    remnz = (div_st[DIV_STEPS].rem != '0);
    mneg_ext = {Q_W'(0), remnz};
    mneg = {1'b0, div_st[DIV_STEPS].q} + mneg_ext;
    win = !div_st[DIV_STEPS].vzero && !div_st[DIV_STEPS].neg && !div_st[DIV_STEPS].ovf &&
          ((div_st[DIV_STEPS].q < Q_W'(horizon)) ||
           ((div_st[DIV_STEPS].q == Q_W'(horizon)) && !remnz));
    p1_next.valid = div_st[DIV_STEPS].valid;
    p1_next.win = win;
    p1_next.coll_en = win || div_st[DIV_STEPS].vzero;
    if (div_st[DIV_STEPS].vzero) begin
      p1_next.tq = '0;
    end else if (!div_st[DIV_STEPS].neg) begin
      p1_next.tq = (div_st[DIV_STEPS].ovf || div_st[DIV_STEPS].q[Q_W-1]) ? TQ_MAX :
                   div_st[DIV_STEPS].q;
    end else begin
      p1_next.tq = (div_st[DIV_STEPS].ovf || (mneg > {1'b0, TQ_MIN})) ? TQ_MIN :
                   (~mneg[TQ_W-1:0] + TQ_W'(1));
    end
    p1_next.tqw = div_st[DIV_STEPS].q[HOR_W-1:0];
    p1_next.d = div_st[DIV_STEPS].d;
    p1_next.v = div_st[DIV_STEPS].v;
    p1_next.d2s = div_st[DIV_STEPS].d2s;
  end

  always_comb begin
    c2 = p4.cc[0] + p4.cc[1] + p4.cc[2];
    sq_init.valid = p4.valid;
    sq_init.coll_en = p4.coll_en;
    sq_init.tq = p4.tq;
    sq_init.n = p4.win ? c2 : SQ_W'(p4.d2s);
    sq_init.rem = '0;
    sq_init.r = '0;
  end

  always_comb begin
    res_next.collision = sq[ROOT_STEPS].coll_en &&
                         (sq[ROOT_STEPS].r <= ROOT_W'({safety, 4'd0}));
    res_next.min_distance = sq[ROOT_STEPS].r[DIST_W-1:0];
    res_next.time_to_closest = sq[ROOT_STEPS].tq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) begin
        div_st[k].valid <= 1'b0;
      end
      p1.valid <= 1'b0;
      p2.valid <= 1'b0;
      p3.valid <= 1'b0;
      p4.valid <= 1'b0;
      for (int k = 0; k <= ROOT_STEPS; k++) begin
        sq[k].valid <= 1'b0;
      end
    end else if (en) begin
      s1.valid <= pair.valid;
      s1.d[0] <= D_W'(pair.own_pos_x) - D_W'(pair.peer_pos_x);
      s1.d[1] <= D_W'(pair.own_pos_y) - D_W'(pair.peer_pos_y);
      s1.d[2] <= D_W'(pair.own_pos_z) - D_W'(pair.peer_pos_z);
      s1.v[0] <= V_W'(pair.own_vel_x) - V_W'(pair.peer_vel_x);
      s1.v[1] <= V_W'(pair.own_vel_y) - V_W'(pair.peer_vel_y);
      s1.v[2] <= V_W'(pair.own_vel_z) - V_W'(pair.peer_vel_z);

      s2.valid <= s1.valid;
      s2.d <= s1.d;
      s2.v <= s1.v;
      for (int i = 0; i < 3; i++) begin
        s2.dv[i] <= DV_W'($signed(s1.d[i]) * $signed(s1.v[i]));
        s2.vv[i] <= VV_W'($signed(s1.v[i]) * $signed(s1.v[i]));
        s2.dd[i] <= DD_W'($signed(s1.d[i]) * $signed(s1.d[i]));
      end

      s3.valid <= s2.valid;
      s3.d <= s2.d;
      s3.v <= s2.v;
      s3.dot <= DOT_W'($signed(s2.dv[0])) + DOT_W'($signed(s2.dv[1])) +
                DOT_W'($signed(s2.dv[2]));
      s3.v2 <= s2.vv[0] + s2.vv[1] + s2.vv[2];
      s3.d2 <= s2.dd[0] + s2.dd[1] + s2.dd[2];

      div_st[0] <= div_init;
      for (int k = 0; k < DIV_STEPS; k++) begin
        div_st[k+1] <= div_step(div_st[k]);
      end

      p1 <= p1_next;

      p2.valid <= p1.valid;
      p2.win <= p1.win;
      p2.coll_en <= p1.coll_en;
      p2.tq <= p1.tq;
      p2.d <= p1.d;
      p2.d2s <= p1.d2s;
      for (int i = 0; i < 3; i++) begin
        p2.prod[i] <= PROD_W'($signed(p1.v[i]) * $signed({1'b0, p1.tqw}));
      end

      p3.valid <= p2.valid;
      p3.win <= p2.win;
      p3.coll_en <= p2.coll_en;
      p3.tq <= p2.tq;
      p3.d2s <= p2.d2s;
      for (int i = 0; i < 3; i++) begin
        p3.c[i] <= C_W'($signed({p2.d[i], 4'd0})) + C_W'($signed(p2.prod[i]) >>> 12);
      end

      p4.valid <= p3.valid;
      p4.win <= p3.win;
      p4.coll_en <= p3.coll_en;
      p4.tq <= p3.tq;
      p4.d2s <= p3.d2s;
      for (int i = 0; i < 3; i++) begin
        p4.cc[i] <= SQ_W'($signed(p3.c[i]) * $signed(p3.c[i]));
      end

      sq[0] <= sq_init;
      for (int k = 0; k < ROOT_STEPS; k++) begin
        sq[k+1] <= sq_step(sq[k]);
      end
    end
  end

  // 2-entry output buffer
  assign push = en && sq[ROOT_STEPS].valid;
  assign pop = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: cnt <= cnt + 2'd1;
        2'b01: cnt <= cnt - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) begin
          buf0 <= res_next;
        end else begin
          buf1 <= res_next;
        end
      end
      2'b01: buf0 <= buf1;
      2'b11: buf0 <= res_next;
      default: ;
    endcase
  end

  assign result.valid = (cnt != 2'd0);
  assign result.collision = buf0.collision;
  assign result.min_distance = buf0.min_distance;
  assign result.time_to_closest = buf0.time_to_closest;

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer count out of range");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) |-> !pair.ready)
    else $error("request accepted with full output buffer");

  a_win_time: assert property (@(posedge clk) disable iff (rst)
    (p1.valid && p1.win) |-> (!p1.tq[TQ_W-1] && (p1.tq <= TQ_W'(horizon))))
    else $error("in-window approach time outside horizon");

  a_still_time: assert property (@(posedge clk) disable iff (rst)
    (div_st[DIV_STEPS].valid && div_st[DIV_STEPS].vzero && en) |=> (p1.tq == '0))
    else $error("zero relative motion must report time zero");

endmodule
`default_nettype wire
